>>> hdl/record_exchange_sorter_top_assert.svh
// assertion macros for the record exchange sorter checker
// depends on a clock named clk and an active-low reset named arst_n in the including scope
`ifndef RECORD_EXCHANGE_SORTER_TOP_ASSERT_SVH
`define RECORD_EXCHANGE_SORTER_TOP_ASSERT_SVH

// same-cycle implication
`define RXS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RXS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/rxs_pkg.sv
// shared types and constants of the record exchange sorter
// no dependencies
package rxs_pkg;

	localparam int ID_W            = 27;
	localparam int SCORE_W         = 16;
	localparam int RANK_W          = 4;
	localparam int MAX_RECORDS_DEF = 16;

	typedef logic [RANK_W-1:0] rank_t;

	// one stored record
	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [SCORE_W-1:0] score;
	} rec_t;

	// one request
	typedef struct packed {
		logic [ID_W-1:0]    record_id;
		logic [SCORE_W-1:0] total_score;
		logic               last_record;
	} in_item_t;

	// one result
	typedef struct packed {
		rank_t              rank;
		logic [ID_W-1:0]    out_id;
		logic [SCORE_W-1:0] out_score;
		logic               end_of_set;
		logic               overflowed;
	} res_item_t;

endpackage

>>> hdl/record_exchange_sorter_top.sv
// top level of the record exchange sorter: load, in-place exchange sort, ordered emission
// depends on rxs_pkg, rxs_ram, rxs_cmp
//
//   channel   handshake                 payload
//   request   start / busy              item (in_item_t)
//   result    res_strobe (one cycle)    result (res_item_t)
//   config    cfg_we                    cfg_wdata (sort_key)
//
// a request without the last mark is absorbed and leaves busy low
// a last request with n records in store sorts them in place row by row, one record
// read and compared per cycle on the single ram read port while a row is scanned, then emits them
// results appear one per cycle, the last one in the same cycle as busy falls
// arst_n clears the sequencer, the fill count, the overflow flag and sort_key
// the receiver cannot stall results
module record_exchange_sorter_top #(
	parameter int MAX_RECORDS = rxs_pkg::MAX_RECORDS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  rxs_pkg::in_item_t    item,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,
	output logic                 res_strobe,
	output rxs_pkg::res_item_t   result
);

	localparam int AW = $clog2(MAX_RECORDS);
	localparam int CW = $clog2(MAX_RECORDS + 1);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_RECORDS);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_ROW    = 6'b000010,
		S_ROWGET = 6'b000100,
		S_SCAN   = 6'b001000,
		S_WB     = 6'b010000,
		S_EMIT   = 6'b100000
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_m1;
	logic [AW-1:0]     last_idx;
	logic              ovf_q;
	logic              sort_key_q;
	logic              key_q;
	logic [AW-1:0]     i_q;
	logic [AW-1:0]     q_q;
	rxs_pkg::rec_t     cur_q;
	logic              strobe_s1;
	rxs_pkg::rank_t    rank_s1;
	logic              eos_s1;
	logic              ovf_s1;

	logic              accept;
	logic              has_room;
	logic              swap;
	logic              precedes;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	rxs_pkg::rec_t     ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	rxs_pkg::rec_t     ram_rdata;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign has_room = (count_q < MAX_C);
	assign count_m1 = count_q - CW'(1);
	assign last_idx = count_m1[AW-1:0];

	// record store
	rxs_ram #(
		.W ($bits(rxs_pkg::rec_t)),
		.D (MAX_RECORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// shared comparator: held entry i against entry q
	rxs_cmp u_cmp (
		.sort_key (key_q),
		.a        (cur_q),
		.b        (ram_rdata),
		.precedes (precedes)
	);

	// entry i never swaps with itself, and its ram copy is stale while held
	assign swap = (state_q == S_SCAN) && (q_q != i_q) && precedes;

	// ram port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = cur_q;
		ram_re    = 1'b0;
		ram_raddr = '0;
		case (state_q)
			S_IDLE: begin
				ram_we    = accept && has_room;
				ram_waddr = count_q[AW-1:0];
				ram_wdata = '{id: item.record_id, score: item.total_score};
			end
			S_ROW: begin
				ram_re    = 1'b1;
				ram_raddr = i_q;
			end
			S_ROWGET: begin
				ram_re    = 1'b1;
				ram_raddr = '0;
			end
			S_SCAN: begin
				ram_we    = swap;
				ram_waddr = q_q;
				ram_re    = (q_q != last_idx);
				ram_raddr = q_q + AW'(1);
			end
			S_WB: begin
				ram_we    = 1'b1;
				ram_waddr = i_q;
			end
			S_EMIT: begin
				ram_re    = 1'b1;
				ram_raddr = q_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// sort key register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_key_q <= 1'b0;
		end else if (cfg_we) begin
			sort_key_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			key_q     <= 1'b0;
			i_q       <= '0;
			q_q       <= '0;
			strobe_s1 <= 1'b0;
		end else begin
			strobe_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (has_room) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (item.last_record) begin
							key_q   <= sort_key_q;
							i_q     <= '0;
							state_q <= S_ROW;
						end
					end
				end
				S_ROW: begin
					q_q     <= '0;
					state_q <= S_ROWGET;
				end
				S_ROWGET: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (q_q == last_idx) begin
						state_q <= S_WB;
					end else begin
						q_q <= q_q + AW'(1);
					end
				end
				S_WB: begin
					if (i_q == last_idx) begin
						q_q     <= '0;
						state_q <= S_EMIT;
					end else begin
						i_q     <= i_q + AW'(1);
						state_q <= S_ROW;
					end
				end
				S_EMIT: begin
					strobe_s1 <= 1'b1;
					if (q_q == last_idx) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						q_q <= q_q + AW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// held entry: loaded at row start, replaced by entry q on a swap
	always_ff @(posedge clk) begin
		if (state_q == S_ROWGET) begin
			cur_q <= ram_rdata;
		end else if (swap) begin
			cur_q <= ram_rdata;
		end
	end

	// result side-band, aligned with the registered ram read
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT) begin
			rank_s1 <= rxs_pkg::rank_t'(q_q);
			eos_s1  <= (q_q == last_idx);
			ovf_s1  <= ovf_q;
		end
	end

	// result ports
	assign res_strobe        = strobe_s1;
	assign result.rank       = rank_s1;
	assign result.out_id     = ram_rdata.id;
	assign result.out_score  = ram_rdata.score;
	assign result.end_of_set = eos_s1;
	assign result.overflowed = ovf_s1;

endmodule

>>> hdl/rxs_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module rxs_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hdl/rxs_cmp.sv
// key comparator shared by every step of the exchange sort
// depends on rxs_pkg
module rxs_cmp (
	input  logic          sort_key,
	input  rxs_pkg::rec_t a,
	input  rxs_pkg::rec_t b,
	output logic          precedes
);

	// id ascending or score descending, strict
	always_comb begin
		if (sort_key) begin
			precedes = (a.id < b.id);
		end else begin
			precedes = (a.score > b.score);
		end
	end

endmodule

>>> hdl/rxs_chk.sv
// port-level checker for the record exchange sorter, bound to the top level
// depends on rxs_pkg and record_exchange_sorter_top_assert.svh
`include "record_exchange_sorter_top_assert.svh"

module rxs_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input rxs_pkg::in_item_t   item,
	input logic                res_strobe,
	input rxs_pkg::res_item_t  result
);

	// results only come out of a busy period
	`RXS_ASSERT_NOW(a_strobe_after_busy, res_strobe, $past(busy), "result without busy period")

	// a request without the last mark is absorbed and leaves busy low
	`RXS_ASSERT_NEXT(a_plain_load, start && !busy && !item.last_record, !busy, "load kept block busy")

	// a last request starts the sort
	`RXS_ASSERT_NEXT(a_last_starts, start && !busy && item.last_record, busy, "sort did not start")

	// emission is a gapless burst closed by end_of_set
	`RXS_ASSERT_NEXT(a_burst_gapless, res_strobe && !result.end_of_set, res_strobe, "gap in burst")

	`RXS_ASSERT_NEXT(a_burst_ends, res_strobe && result.end_of_set, !res_strobe, "burst ran past end")

endmodule

bind record_exchange_sorter_top rxs_chk u_rxs_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.item       (item),
	.res_strobe (res_strobe),
	.result     (result)
);
